// ===== rtl/qtd_pkg.sv =====
// Shared constants and result type for the quadtree region decoder.
`default_nettype none

package qtd_pkg;

    localparam int CFG_W   = 11;
    localparam int SYM_W   = 8;
    localparam int COORD_W = 10;
    localparam int SPLIT_W = 19;

    localparam logic [SPLIT_W-1:0] SPLIT_MAX = 19'd349525;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
    localparam logic [SYM_W-1:0] SYM_A    = 8'h61;
    localparam logic [SYM_W-1:0] SYM_Z    = 8'h7A;

    // symbol classes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_SPLIT = 2'd1;
    localparam logic [1:0] OP_DIGIT = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // child slots inside a stack entry, in push order
    localparam logic [1:0] CHILD_BR = 2'd0;
    localparam logic [1:0] CHILD_BL = 2'd1;
    localparam logic [1:0] CHILD_TR = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] row_top;
        logic [COORD_W-1:0] col_left;
        logic [COORD_W-1:0] row_bottom;
        logic [COORD_W-1:0] col_right;
        logic [SYM_W-1:0]   fill_symbol;
        logic [SPLIT_W-1:0] split_count;
        logic               image_done;
    } fill_t;

endpackage

`default_nettype wire

// ===== rtl/qtd_sym_if.sv =====
// Symbol input channel: valid/ready with symbol and start request.
`default_nettype none

interface qtd_sym_if;
    logic                       valid;
    logic                       ready;
    logic [qtd_pkg::SYM_W-1:0]  symbol;
    logic                       start_req;

    modport source (output valid, output symbol, output start_req, input ready);
    modport sink   (input valid, input symbol, input start_req, output ready);
endinterface

`default_nettype wire

// ===== rtl/qtd_fill_if.sv =====
// Fill result channel: valid/ready with rectangle, letter, split count and done.
`default_nettype none

interface qtd_fill_if;
    logic                          valid;
    logic                          ready;
    logic [qtd_pkg::COORD_W-1:0]   row_top;
    logic [qtd_pkg::COORD_W-1:0]   col_left;
    logic [qtd_pkg::COORD_W-1:0]   row_bottom;
    logic [qtd_pkg::COORD_W-1:0]   col_right;
    logic [qtd_pkg::SYM_W-1:0]     fill_symbol;
    logic [qtd_pkg::SPLIT_W-1:0]   split_count;
    logic                          image_done;

    modport source (output valid, output row_top, output col_left, output row_bottom,
                    output col_right, output fill_symbol, output split_count,
                    output image_done, input ready);
    modport sink   (input valid, input row_top, input col_left, input row_bottom,
                    input col_right, input fill_symbol, input split_count,
                    input image_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/quadtree_region_decoder_core.sv =====
// Quadtree region decoder: region stack in flops plus one-port RAM, registered fill output.
//
//  channel   | dir | handshake   | payload
//  ----------+-----+-------------+----------------------------------------------
//  sym_in    | in  | valid/ready | symbol, start_req
//  fill_out  | out | valid/ready | row_top, col_left, row_bottom, col_right,
//            |     |             | fill_symbol, split_count, image_done
//  cfg       | in  | wr_en only  | cfg_wr_data = side length
//
//  One symbol per cycle while the skid slot is empty; each fill result is registered.
//  Each split with a kept child pushes its parent region and child mask as one entry;
//  the top two entries sit in flops and the rest in a RAM with one access per cycle.
//  A skid register holds one result, so input stalls only when both output slots fill.
//  Reset clears counters and the region; the stack RAM needs no clearing pass.
`default_nettype none

module quadtree_region_decoder_core #(
    parameter int MAX_SIDE    = 1024,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [qtd_pkg::CFG_W-1:0]   cfg_wr_data,
    qtd_sym_if.sink                          sym_in,
    qtd_fill_if.source                       fill_out
);

    localparam int CW  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int CWX = (CW > qtd_pkg::COORD_W) ? CW : qtd_pkg::COORD_W;
    localparam int SW  = (qtd_pkg::CFG_W > CW + 1) ? qtd_pkg::CFG_W : CW + 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [CW-1:0] r0;
        logic [CW-1:0] c0;
        logic [CW-1:0] r1;
        logic [CW-1:0] c1;
    } region_t;

    typedef struct packed {
        region_t    parent;
        logic [2:0] mask;
    } entry_t;

    function automatic region_t child_of(region_t p, logic [1:0] which);
        logic [CW:0]   rs;
        logic [CW:0]   cs;
        logic [CW-1:0] mr;
        logic [CW-1:0] mc;
        region_t       c;
        rs = {1'b0, p.r0} + {1'b0, p.r1};
        cs = {1'b0, p.c0} + {1'b0, p.c1};
        mr = rs[CW:1];
        mc = cs[CW:1];
        case (which)
            qtd_pkg::CHILD_TR: c = '{r0: p.r0, c0: mc + CW'(1), r1: mr, c1: p.c1};
            qtd_pkg::CHILD_BL: c = '{r0: mr + CW'(1), c0: p.c0, r1: p.r1, c1: mc};
            default:           c = '{r0: mr + CW'(1), c0: mc + CW'(1), r1: p.r1, c1: p.c1};
        endcase
        return c;
    endfunction

    function automatic logic [qtd_pkg::COORD_W-1:0] to_coord(logic [CW-1:0] v);
        logic [CWX-1:0] x;
        x = CWX'(v);
        return x[qtd_pkg::COORD_W-1:0];
    endfunction

    // state
    logic [qtd_pkg::CFG_W-1:0]   side_reg;
    region_t                     cur_reg, cur_next;
    logic [SPW-1:0]              sp_reg, sp_next;
    logic [SPW-1:0]              ent_reg, ent_next;
    logic [qtd_pkg::SPLIT_W-1:0] splits_reg, splits_next;
    logic                        active_reg, active_next;
    entry_t                      top_reg, top_next;
    entry_t                      second_reg, second_next;
    logic                        from_ram_reg, from_ram_next;
    entry_t                      rd_data_reg;
    entry_t                      mem [STACK_DEPTH];

    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    entry_t                      mem_wdata;
    logic [SPW-1:0]              waddr_full, raddr_full;

    // output slots
    qtd_pkg::fill_t              out_data_reg, out_data_next;
    qtd_pkg::fill_t              skid_data_reg, skid_data_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        skid_valid_reg, skid_valid_next;
    qtd_pkg::fill_t              res;
    logic                        res_valid;

    // decode
    logic                        accept;
    logic [1:0]                  op;
    logic [SW-1:0]               side_sat;
    logic [SW-1:0]               side_edge;
    region_t                     whole;
    region_t                     g;
    logic [SPW-1:0]              sp_eff, ent_eff;
    logic [qtd_pkg::SPLIT_W-1:0] splits_eff;
    logic                        active_eff;
    entry_t                      second_fwd;
    logic [CW:0]                 mr_sum, mc_sum;
    logic [CW-1:0]               mr, mc;
    logic                        single, right, lower;
    logic [2:0]                  cand, keep;
    logic [SPW-1:0]              cnt;
    logic [1:0]                  pick;
    logic [2:0]                  mask_left;

    assign accept       = sym_in.valid && sym_in.ready;
    assign sym_in.ready = !skid_valid_reg;

    always_comb
    begin
        if (sym_in.symbol == qtd_pkg::SYM_STAR)
        begin
            op = qtd_pkg::OP_SPLIT;
        end
        else if (sym_in.symbol inside {[qtd_pkg::SYM_ZERO:qtd_pkg::SYM_NINE]})
        begin
            op = qtd_pkg::OP_DIGIT;
        end
        else if (sym_in.symbol inside {[qtd_pkg::SYM_A:qtd_pkg::SYM_Z]})
        begin
            op = qtd_pkg::OP_FILL;
        end
        else
        begin
            op = qtd_pkg::OP_NONE;
        end
    end

    // whole square from the configured side, clamped to 1..MAX_SIDE
    always_comb
    begin
        if (side_reg == '0)
        begin
            side_sat = SW'(1);
        end
        else if (SW'(side_reg) > SW'(MAX_SIDE))
        begin
            side_sat = SW'(MAX_SIDE);
        end
        else
        begin
            side_sat = SW'(side_reg);
        end
        side_edge = side_sat - SW'(1);
        whole     = '{r0: '0, c0: '0, r1: side_edge[CW-1:0], c1: side_edge[CW-1:0]};
    end

    // state as seen by this symbol, after an optional restart
    always_comb
    begin
        if (sym_in.start_req)
        begin
            g          = whole;
            sp_eff     = '0;
            ent_eff    = '0;
            splits_eff = '0;
            active_eff = 1'b1;
        end
        else
        begin
            g          = cur_reg;
            sp_eff     = sp_reg;
            ent_eff    = ent_reg;
            splits_eff = splits_reg;
            active_eff = active_reg;
        end
        second_fwd = from_ram_reg ? rd_data_reg : second_reg;
    end

    // split geometry and push selection
    always_comb
    begin
        mr_sum  = {1'b0, g.r0} + {1'b0, g.r1};
        mc_sum  = {1'b0, g.c0} + {1'b0, g.c1};
        mr      = mr_sum[CW:1];
        mc      = mc_sum[CW:1];
        single  = (g.r0 == g.r1) && (g.c0 == g.c1);
        right   = mc < g.c1;
        lower   = mr < g.r1;
        cand[qtd_pkg::CHILD_BR] = right && lower && !single;
        cand[qtd_pkg::CHILD_BL] = lower && !single;
        cand[qtd_pkg::CHILD_TR] = right && !single;
        cnt  = sp_eff;
        keep = '0;
        // drop parts that do not fit, in push order
        for (int i = 0; i < 3; i++)
        begin
            if (cand[i] && (cnt < SPW'(STACK_DEPTH)))
            begin
                keep[i] = 1'b1;
                cnt     = cnt + SPW'(1);
            end
        end
    end

    // pop selection from the top entry, last pushed first
    always_comb
    begin
        if (top_reg.mask[qtd_pkg::CHILD_TR])
        begin
            pick = qtd_pkg::CHILD_TR;
        end
        else if (top_reg.mask[qtd_pkg::CHILD_BL])
        begin
            pick = qtd_pkg::CHILD_BL;
        end
        else
        begin
            pick = qtd_pkg::CHILD_BR;
        end
        mask_left       = top_reg.mask;
        mask_left[pick] = 1'b0;
    end

    always_comb
    begin
        cur_next      = cur_reg;
        sp_next       = sp_reg;
        ent_next      = ent_reg;
        splits_next   = splits_reg;
        active_next   = active_reg;
        top_next      = top_reg;
        second_next   = second_reg;
        from_ram_next = from_ram_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        waddr_full    = ent_eff - SPW'(2);
        raddr_full    = ent_eff - SPW'(3);
        mem_wdata     = second_fwd;
        res_valid     = 1'b0;
        res           = '{row_top:     to_coord(g.r0),
                          col_left:    to_coord(g.c0),
                          row_bottom:  to_coord(g.r1),
                          col_right:   to_coord(g.c1),
                          fill_symbol: sym_in.symbol,
                          split_count: splits_eff,
                          image_done:  (sp_eff == '0)};

        if (accept)
        begin
            cur_next    = g;
            sp_next     = sp_eff;
            ent_next    = ent_eff;
            splits_next = splits_eff;
            active_next = active_eff;
            if (sym_in.start_req)
            begin
                from_ram_next = 1'b0;
            end

            if (active_eff)
            begin
                case (op)
                    qtd_pkg::OP_SPLIT:
                    begin
                        if (splits_eff < qtd_pkg::SPLIT_MAX)
                        begin
                            splits_next = splits_eff + qtd_pkg::SPLIT_W'(1);
                        end
                        if (!single)
                        begin
                            cur_next.r1 = mr;
                            cur_next.c1 = mc;
                        end
                        if (keep != '0)
                        begin
                            // push: top moves down, old second spills to RAM
                            sp_next       = cnt;
                            ent_next      = ent_eff + SPW'(1);
                            top_next      = '{parent: g, mask: keep};
                            second_next   = top_reg;
                            from_ram_next = 1'b0;
                            mem_we        = (ent_eff >= SPW'(2));
                        end
                    end
                    qtd_pkg::OP_FILL:
                    begin
                        res_valid = 1'b1;
                        if (sp_eff == '0)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            sp_next  = sp_eff - SPW'(1);
                            cur_next = child_of(top_reg.parent, pick);
                            if (mask_left == '0)
                            begin
                                // entry exhausted: second moves up, refill from RAM
                                ent_next      = ent_eff - SPW'(1);
                                top_next      = second_fwd;
                                mem_re        = (ent_eff >= SPW'(3));
                                from_ram_next = (ent_eff >= SPW'(3));
                            end
                            else
                            begin
                                top_next.mask = mask_left;
                            end
                        end
                    end
                    default:
                    begin
                        // digits and other symbols leave the state as is
                    end
                endcase
            end
        end
        mem_waddr = waddr_full[AW-1:0];
        mem_raddr = raddr_full[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= qtd_pkg::CFG_W'(1);
            cur_reg      <= '0;
            sp_reg       <= '0;
            ent_reg      <= '0;
            splits_reg   <= '0;
            active_reg   <= 1'b1;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_reg <= cfg_wr_data;
            end
            cur_reg      <= cur_next;
            sp_reg       <= sp_next;
            ent_reg      <= ent_next;
            splits_reg   <= splits_next;
            active_reg   <= active_next;
            from_ram_reg <= from_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
    end

    // stack RAM, one access per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // output register with one skid slot
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || fill_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_data_next  = res;
                skid_valid_next = res_valid;
            end
            else
            begin
                out_data_next   = res;
                out_valid_next  = res_valid;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign fill_out.valid       = out_valid_reg;
    assign fill_out.row_top     = out_data_reg.row_top;
    assign fill_out.col_left    = out_data_reg.col_left;
    assign fill_out.row_bottom  = out_data_reg.row_bottom;
    assign fill_out.col_right   = out_data_reg.col_right;
    assign fill_out.fill_symbol = out_data_reg.fill_symbol;
    assign fill_out.split_count = out_data_reg.split_count;
    assign fill_out.image_done  = out_data_reg.image_done;

`ifndef SYNTHESIS
    a_ent_le_sp: assert property (@(posedge clk) disable iff (!rst_n)
        ent_reg <= sp_reg)
        else $error("stack entry count exceeds region count");

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("region count beyond stack depth");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while output slot is empty");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (sp_reg == '0))
        else $error("decoding stopped with pending regions");

    a_fwd_depth: assert property (@(posedge clk) disable iff (!rst_n)
        from_ram_reg |-> (ent_reg >= SPW'(2)))
        else $error("second entry taken from RAM with shallow stack");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_quadtree_region_decoder_core.sv =====
// Self-checking testbench for the quadtree region decoder core.
`timescale 1ns / 100ps

module tb_quadtree_region_decoder_core;

    localparam int MAX_SIDE    = 1024;
    localparam int STACK_DEPTH = 32;
    localparam int SETTLE      = 6;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [qtd_pkg::SYM_W-1:0] sym;
        logic                      start;
    } code_sym_t;

    typedef struct {
        logic [qtd_pkg::SYM_W-1:0] sym;
        logic                      start;
        int                        side;
        logic                      typed;
        qtd_pkg::fill_t            fill;
    } step_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [qtd_pkg::CFG_W-1:0] cfg_wr_data;

    qtd_sym_if  sym_bus ();
    qtd_fill_if fill_bus ();

    quadtree_region_decoder_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sym_in      (sym_bus),
        .fill_out    (fill_bus)
    );

    // decoder image kept by the bench
    logic [qtd_pkg::CFG_W-1:0] side_cfg;
    int               cur_r0, cur_c0, cur_r1, cur_c1;
    int               pend_r0 [STACK_DEPTH];
    int               pend_c0 [STACK_DEPTH];
    int               pend_r1 [STACK_DEPTH];
    int               pend_c1 [STACK_DEPTH];
    int               pend_count;
    int               split_tally;
    logic             decoding;

    qtd_pkg::fill_t   pending_fills [$];
    step_row_t        directed_rows [$];
    code_sym_t        symbol_stream [$];
    int               fault_count;
    logic             hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("quadtree_region_decoder_core regression: fail");
        $finish;
    end

    function automatic void open_image();
        int s;
        s = int'(side_cfg);
        if (s == 0) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        cur_r0 = 0;
        cur_c0 = 0;
        cur_r1 = s - 1;
        cur_c1 = s - 1;
        pend_count = 0;
        split_tally = 0;
        decoding = 1'b1;
    endfunction

    function automatic void push_pending(input int r0, input int c0, input int r1,
                                         input int c1);
        // drop a part that does not fit
        if (pend_count >= STACK_DEPTH) return;
        pend_r0[pend_count] = r0;
        pend_c0[pend_count] = c0;
        pend_r1[pend_count] = r1;
        pend_c1[pend_count] = c1;
        pend_count++;
    endfunction

    function automatic logic decode_symbol(input logic [qtd_pkg::SYM_W-1:0] sym,
                                           input logic start,
                                           output qtd_pkg::fill_t fill);
        int   mr, mc;
        logic right, lower;
        fill = '0;
        if (start) open_image();
        if (!decoding) return 1'b0;
        if (sym == qtd_pkg::SYM_STAR)
        begin
            if (split_tally < int'(qtd_pkg::SPLIT_MAX)) split_tally++;
            if (cur_r0 != cur_r1 || cur_c0 != cur_c1)
            begin
                mr = (cur_r0 + cur_r1) >> 1;
                mc = (cur_c0 + cur_c1) >> 1;
                right = (mc + 1 <= cur_c1);
                lower = (mr + 1 <= cur_r1);
                // push order leaves top-right on top of the stack
                if (right && lower) push_pending(mr + 1, mc + 1, cur_r1, cur_c1);
                if (lower) push_pending(mr + 1, cur_c0, cur_r1, mc);
                if (right) push_pending(cur_r0, mc + 1, mr, cur_c1);
                cur_r1 = mr;
                cur_c1 = mc;
            end
            return 1'b0;
        end
        if (sym >= qtd_pkg::SYM_A && sym <= qtd_pkg::SYM_Z)
        begin
            fill.row_top     = cur_r0[qtd_pkg::COORD_W-1:0];
            fill.col_left    = cur_c0[qtd_pkg::COORD_W-1:0];
            fill.row_bottom  = cur_r1[qtd_pkg::COORD_W-1:0];
            fill.col_right   = cur_c1[qtd_pkg::COORD_W-1:0];
            fill.fill_symbol = sym;
            fill.split_count = split_tally[qtd_pkg::SPLIT_W-1:0];
            fill.image_done  = (pend_count == 0);
            if (pend_count == 0)
            begin
                decoding = 1'b0;
            end
            else
            begin
                pend_count--;
                cur_r0 = pend_r0[pend_count];
                cur_c0 = pend_c0[pend_count];
                cur_r1 = pend_r1[pend_count];
                cur_c1 = pend_c1[pend_count];
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void plan(input logic [qtd_pkg::SYM_W-1:0] sym, input logic start,
                                 input int side);
        step_row_t row;
        row.sym   = sym;
        row.start = start;
        row.side  = side;
        row.typed = 1'b0;
        row.fill  = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void plan_fill(input logic [qtd_pkg::SYM_W-1:0] sym, input logic start,
                                      input int side, input int r0, input int c0,
                                      input int r1, input int c1, input int splits,
                                      input logic done);
        step_row_t row;
        row.sym   = sym;
        row.start = start;
        row.side  = side;
        row.typed = 1'b1;
        row.fill.row_top     = r0[qtd_pkg::COORD_W-1:0];
        row.fill.col_left    = c0[qtd_pkg::COORD_W-1:0];
        row.fill.row_bottom  = r1[qtd_pkg::COORD_W-1:0];
        row.fill.col_right   = c1[qtd_pkg::COORD_W-1:0];
        row.fill.fill_symbol = sym;
        row.fill.split_count = splits[qtd_pkg::SPLIT_W-1:0];
        row.fill.image_done  = done;
        directed_rows.push_back(row);
    endfunction

    function automatic void push_code(input logic [qtd_pkg::SYM_W-1:0] sym);
        code_sym_t c;
        c.sym   = sym;
        c.start = 1'b0;
        symbol_stream.push_back(c);
    endfunction

    // well-formed code for an h x w region, with digits and some noise
    task automatic grow_code(input int h, input int w, input int depth);
        int th, bh, lw, rw, k;
        if ((h > 1 || w > 1) && depth < 6 && $urandom_range(99) < 75 - depth * 12)
        begin
            push_code(qtd_pkg::SYM_STAR);
            th = (h + 1) / 2;
            bh = h - th;
            lw = (w + 1) / 2;
            rw = w - lw;
            grow_code(th, lw, depth + 1);
            if (rw > 0) grow_code(th, rw, depth + 1);
            if (bh > 0) grow_code(bh, lw, depth + 1);
            if (bh > 0 && rw > 0) grow_code(bh, rw, depth + 1);
        end
        else
        begin
            if (h == 1 && w == 1 && $urandom_range(7) == 0) push_code(qtd_pkg::SYM_STAR);
            if ($urandom_range(2) == 0)
            begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_code(qtd_pkg::SYM_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(32) == 0) push_code(8'($urandom_range(255)));
            push_code(qtd_pkg::SYM_A + 8'($urandom_range(25)));
        end
    endtask

    task automatic send_symbol(input logic [qtd_pkg::SYM_W-1:0] sym, input logic start,
                               input logic typed, input qtd_pkg::fill_t typed_fill);
        qtd_pkg::fill_t predicted;
        logic           produced;
        @(negedge clk);
        sym_bus.valid     <= 1'b1;
        sym_bus.symbol    <= sym;
        sym_bus.start_req <= start;
        forever
        begin
            @(posedge clk);
            if (sym_bus.ready) break;
        end
        produced = decode_symbol(sym, start, predicted);
        if (typed) pending_fills.push_back(typed_fill);
        else if (produced) pending_fills.push_back(predicted);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles == 0) return;
        @(negedge clk);
        sym_bus.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        sym_bus.valid <= 1'b0;
        while (pending_fills.size() != 0) @(negedge clk);
    endtask

    task automatic write_side(input int value);
        wait_drained();
        // splits and ignored symbols leave no result, so let them settle
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[qtd_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        side_cfg = value[qtd_pkg::CFG_W-1:0];
    endtask

    // result side: stall on a pattern of its own, plus a long hold on request
    initial
    begin : fill_sink
        int mode, span, held;
        fill_bus.ready = 1'b0;
        span = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                fill_bus.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(2);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0: fill_bus.ready <= 1'b1;
                    1: fill_bus.ready <= 1'($urandom_range(1));
                    default: fill_bus.ready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    initial
    begin : fill_check
        qtd_pkg::fill_t seen, want;
        forever
        begin
            @(posedge clk);
            if (rst_n && fill_bus.valid && fill_bus.ready)
            begin
                seen.row_top     = fill_bus.row_top;
                seen.col_left    = fill_bus.col_left;
                seen.row_bottom  = fill_bus.row_bottom;
                seen.col_right   = fill_bus.col_right;
                seen.fill_symbol = fill_bus.fill_symbol;
                seen.split_count = fill_bus.split_count;
                seen.image_done  = fill_bus.image_done;
                if (pending_fills.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected fill: rows %0d..%0d cols %0d..%0d sym %h",
                                 seen.row_top, seen.row_bottom, seen.col_left,
                                 seen.col_right, seen.fill_symbol);
                end
                else
                begin
                    want = pending_fills.pop_front();
                    if (seen.row_top !== want.row_top || seen.col_left !== want.col_left ||
                        seen.row_bottom !== want.row_bottom ||
                        seen.col_right !== want.col_right ||
                        seen.fill_symbol !== want.fill_symbol ||
                        seen.split_count !== want.split_count ||
                        seen.image_done !== want.image_done)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("fill mismatch at %0t", $realtime);
                            $display({"  expected rows %0d..%0d cols %0d..%0d",
                                      " sym %h splits %0d done %0b"},
                                     want.row_top, want.row_bottom, want.col_left,
                                     want.col_right, want.fill_symbol, want.split_count,
                                     want.image_done);
                            $display({"  actual   rows %0d..%0d cols %0d..%0d",
                                      " sym %h splits %0d done %0b"},
                                     seen.row_top, seen.row_bottom, seen.col_left,
                                     seen.col_right, seen.fill_symbol, seen.split_count,
                                     seen.image_done);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        step_row_t row;
        code_sym_t c;
        int        phase, side, eff, first, k, burst;

        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        sym_bus.valid     = 1'b0;
        sym_bus.symbol    = '0;
        sym_bus.start_req = 1'b0;
        hold_request      = 1'b0;
        fault_count       = 0;
        side_cfg          = 1;
        open_image();

        // directed table; side -1 keeps the current register value
        plan_fill(qtd_pkg::SYM_A, 1'b0, -1, 0, 0, 0, 0, 0, 1'b1);  // single cell after reset
        plan(qtd_pkg::SYM_Z, 1'b0, -1);                            // inactive, ignored
        plan(qtd_pkg::SYM_STAR, 1'b1, -1);                         // split of single cell
        plan(qtd_pkg::SYM_ZERO, 1'b0, -1);
        plan(qtd_pkg::SYM_NINE, 1'b0, -1);
        plan(8'h00, 1'b0, -1);
        plan(8'hFF, 1'b0, -1);
        plan(qtd_pkg::SYM_A - 8'd1, 1'b0, -1);                     // just below the letters
        plan(qtd_pkg::SYM_Z + 8'd1, 1'b0, -1);                     // just above the letters
        plan_fill(qtd_pkg::SYM_Z, 1'b0, -1, 0, 0, 0, 0, 1, 1'b1);
        // side saturates
        plan_fill(qtd_pkg::SYM_A + 8'd16, 1'b1, 2047, 0, 0, 1023, 1023, 0, 1'b1);
        plan(qtd_pkg::SYM_STAR, 1'b1, -1);
        plan(qtd_pkg::SYM_A + 8'd1, 1'b0, -1);
        plan(qtd_pkg::SYM_STAR, 1'b0, -1);
        plan(qtd_pkg::SYM_NINE, 1'b0, -1);
        plan(qtd_pkg::SYM_A + 8'd2, 1'b0, -1);
        plan(qtd_pkg::SYM_A + 8'd3, 1'b0, -1);
        plan_fill(qtd_pkg::SYM_A + 8'd12, 1'b1, 0, 0, 0, 0, 0, 0, 1'b1);       // side zero
        plan(qtd_pkg::SYM_STAR, 1'b1, 3);
        for (k = 0; k < 4; k++) plan(qtd_pkg::SYM_A + 8'(k), 1'b0, -1);
        plan_fill(qtd_pkg::SYM_A + 8'd23, 1'b1, 1025, 0, 0, 1023, 1023, 0, 1'b1);
        plan(qtd_pkg::SYM_STAR, 1'b1, 2);
        for (k = 0; k < 4; k++) plan(qtd_pkg::SYM_Z - 8'(k), 1'b0, -1);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            if (row.side >= 0) write_side(row.side);
            send_symbol(row.sym, row.start, row.typed, row.fill);
        end

        // deepest stack: ten splits down to one cell, one more split, then drain
        write_side(MAX_SIDE);
        send_symbol(qtd_pkg::SYM_STAR, 1'b1, 1'b0, '0);
        for (k = 0; k < 10; k++) send_symbol(qtd_pkg::SYM_STAR, 1'b0, 1'b0, '0);
        for (k = 0; k < 32; k++)
            send_symbol(qtd_pkg::SYM_A + 8'($urandom_range(25)), 1'b0, 1'b0, '0);

        for (phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(7))
                0: side = 1;
                1: side = 2;
                2: side = 3;
                3: side = MAX_SIDE;
                4: side = 2047;
                5: side = 0;
                default: side = $urandom_range(1, 2047);
            endcase
            write_side(side);
            eff = (side == 0) ? 1 : (side > MAX_SIDE ? MAX_SIDE : side);
            while (symbol_stream.size() < 55)
            begin
                first = symbol_stream.size();
                grow_code(eff, eff, 0);
                if ($urandom_range(19) != 0) symbol_stream[first].start = 1'b1;
                // broken image: cut the tail off
                if ($urandom_range(19) == 0)
                    for (k = $urandom_range(1, 4); k > 0 && symbol_stream.size() > first + 1;
                         k--)
                        void'(symbol_stream.pop_back());
                if ($urandom_range(9) == 0) push_code(8'($urandom_range(255)));
            end
            burst = 0;
            while (symbol_stream.size() != 0)
            begin
                if (symbol_stream.size() == 35)
                begin
                    if (phase % 3 == 1) hold_request = 1'b1;
                    else if (phase % 3 == 2) wait_drained();
                end
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    if ($urandom_range(2) != 0) pause_sender($urandom_range(1, 6));
                end
                burst--;
                c = symbol_stream.pop_front();
                send_symbol(c.sym, c.start, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fault_count == 0 && pending_fills.size() == 0)
            $display("quadtree_region_decoder_core regression: pass");
        else
            $display("quadtree_region_decoder_core regression: fail");
        $finish;
    end

endmodule
